FILE: rtl/bffa_pkg.sv
package bffa_pkg;

    localparam int UNIT_BITS = 8;
    localparam int OFF_W     = 3;
    localparam logic [UNIT_BITS-1:0] TOP_BIT = 8'h80;

    localparam int SIZE_W    = 11;
    localparam int NEED_W    = 12;
    localparam int START_W   = 10;
    localparam int BLOCK_W   = 10;
    localparam int USED_W    = 11;
    localparam int CLR_W     = 4;

    localparam int S_DATA_W  = 24;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 24;
    localparam int M_USER_W  = 1;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0] lo;
        logic [OFF_W-1:0] hi;
    } row_span_t;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] pos;
        logic             stop;
        logic [CLR_W-1:0] n_clr;
    } row_res_t;

endpackage

FILE: rtl/bffa_ram.sv
module bffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bffa_row.sv
module bffa_row import bffa_pkg::*; #(
    parameter int RUN_W = 11
) (
    input  logic [UNIT_BITS-1:0] data,
    input  logic [UNIT_BITS-1:0] valid,
    input  row_span_t            span,
    input  logic [RUN_W-1:0]     run_in,
    input  logic [NEED_W-1:0]    need,
    output logic [RUN_W-1:0]     run_out,
    output row_res_t             res,
    output logic [UNIT_BITS-1:0] set_data,
    output logic [UNIT_BITS-1:0] clr_data
);

    logic [UNIT_BITS-1:0] used_u;
    logic [UNIT_BITS-1:0] set_m;
    logic [UNIT_BITS-1:0] clr_m;
    logic [RUN_W-1:0]     run;
    logic                 found;
    logic [OFF_W-1:0]     pos;
    logic                 go;

    // unit j of the row sits at bit TOP_BIT >> j
    always_comb
    begin
        for (int j = 0; j < UNIT_BITS; j++)
        begin
            used_u[j] = |(data & (TOP_BIT >> j));
        end
    end

    // free-run count, first unit where the run reaches the need
    always_comb
    begin
        run   = run_in;
        found = 1'b0;
        pos   = '0;
        for (int j = 0; j < UNIT_BITS; j++)
        begin
            if (!found && valid[j])
            begin
                if (used_u[j])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + RUN_W'(1);
                end
                if ({NEED_W'(0), run} == {RUN_W'(0), need})
                begin
                    found = 1'b1;
                    pos   = OFF_W'(j);
                end
            end
        end
    end

    // clear consecutive used units from span.lo
    always_comb
    begin
        go    = 1'b1;
        clr_m = '0;
        for (int j = 0; j < UNIT_BITS; j++)
        begin
            if (OFF_W'(j) >= span.lo)
            begin
                if (go && valid[j] && used_u[j])
                begin
                    clr_m[j] = 1'b1;
                end
                else
                begin
                    go = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < UNIT_BITS; j++)
        begin
            set_m[j] = (OFF_W'(j) >= span.lo) && (OFF_W'(j) <= span.hi);
        end
    end

    always_comb
    begin
        set_data = data;
        clr_data = data;
        for (int j = 0; j < UNIT_BITS; j++)
        begin
            if (set_m[j])
            begin
                set_data = set_data | (TOP_BIT >> j);
            end
            if (clr_m[j])
            begin
                clr_data = clr_data & ~(TOP_BIT >> j);
            end
        end
    end

    assign run_out   = run;
    assign res.found = found;
    assign res.pos   = pos;
    assign res.stop  = !go;
    assign res.n_clr = CLR_W'($countones(clr_m));

endmodule

FILE: rtl/bitmap_first_fit_allocator.sv
// allocate: the map rows are scanned for a free run, the found block is marked row by row,
// then the result is registered; free: used units are cleared from the start index, and a null or
// out-of-pool free goes straight to the result
// flow: one transaction in flight; the next input is taken once the result is registered
// reset: control clears at once, then a clearing pass writes zero to every row of the map
// while no input is taken
module bitmap_first_fit_allocator import bffa_pkg::*; #(
    parameter int POOL_UNITS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // size, start_index, zero pad
    input  logic [S_USER_W-1:0] s_axis_tuser,  // operation, is_null
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // block_start, used_units, zero pad
    output logic [M_USER_W-1:0] m_axis_tuser   // ok
);

    localparam int ROWS     = (POOL_UNITS + UNIT_BITS - 1) / UNIT_BITS;
    localparam int RA_W     = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int U_W      = $clog2(POOL_UNITS + 1);
    localparam int W2       = U_W + SIZE_W;
    localparam int W3       = U_W + START_W;
    localparam int LAST_N   = POOL_UNITS - (ROWS - 1) * UNIT_BITS;
    localparam logic [RA_W-1:0]      LAST_ROW   = RA_W'(ROWS - 1);
    localparam logic [UNIT_BITS-1:0] LAST_VALID = UNIT_BITS'((1 << LAST_N) - 1);

    state_t              state_reg, state_next;
    logic [RA_W-1:0]     row_reg, row_next;
    logic [U_W-1:0]      run_reg, run_next;
    logic [U_W-1:0]      cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [OFF_W-1:0]    lo_reg, lo_next;
    logic [RA_W-1:0]     last_row_reg, last_row_next;
    logic [OFF_W-1:0]    last_off_reg, last_off_next;
    logic                pend_ok_reg, pend_ok_next;
    logic [U_W-1:0]      pend_blk_reg, pend_blk_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg, m_ok_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                 wr_en;
    logic [RA_W-1:0]      wr_addr;
    logic [UNIT_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [RA_W-1:0]      rd_addr;
    logic [UNIT_BITS-1:0] rd_data;

    logic [UNIT_BITS-1:0] row_valid;
    row_span_t            span;
    logic [NEED_W-1:0]    need;
    logic [U_W-1:0]       run_out;
    row_res_t             res;
    logic [UNIT_BITS-1:0] set_data;
    logic [UNIT_BITS-1:0] clr_data;

    logic [SIZE_W-1:0]    in_size;
    logic [START_W-1:0]   in_start;
    logic [W3-1:0]        start_w;
    logic                 start_ok;
    logic [U_W-1:0]       start_u;
    logic [U_W-1:0]       hit_unit;
    logic [W2-1:0]        blk_w;
    logic [U_W-1:0]       blk_u;
    logic [U_W-1:0]       last_u;
    logic [W2-1:0]        cnt_add_w;
    logic [W2-1:0]        blk_out_w;
    logic [W2-1:0]        cnt_out_w;

    bffa_ram #(
        .WIDTH (UNIT_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bffa_row #(
        .RUN_W (U_W)
    ) u_row (
        .data     (rd_data),
        .valid    (row_valid),
        .span     (span),
        .run_in   (run_reg),
        .need     (need),
        .run_out  (run_out),
        .res      (res),
        .set_data (set_data),
        .clr_data (clr_data)
    );

    assign in_size   = s_axis_tdata[SIZE_W-1:0];
    assign in_start  = s_axis_tdata[SIZE_W+START_W-1:SIZE_W];
    assign start_w   = W3'(in_start);
    assign start_ok  = start_w < W3'(POOL_UNITS);
    assign start_u   = start_w[U_W-1:0];

    assign need      = NEED_W'(size_reg) + NEED_W'(2);
    assign row_valid = (row_reg == LAST_ROW) ? LAST_VALID : '1;
    assign hit_unit  = U_W'({row_reg, res.pos});
    assign blk_w     = W2'(hit_unit) - W2'(size_reg);
    assign blk_u     = blk_w[U_W-1:0];
    assign last_u    = hit_unit - U_W'(1);
    assign cnt_add_w = W2'(cnt_reg) + W2'(size_reg);
    assign blk_out_w = W2'(pend_blk_reg);
    assign cnt_out_w = W2'(cnt_reg);

    assign span.lo = lo_reg;
    assign span.hi = (state_reg == ST_MARK && row_reg == last_row_reg) ? last_off_reg : '1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            row_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg      <= run_next;
        size_reg     <= size_next;
        lo_reg       <= lo_next;
        last_row_reg <= last_row_next;
        last_off_reg <= last_off_next;
        pend_ok_reg  <= pend_ok_next;
        pend_blk_reg <= pend_blk_next;
        m_ok_reg     <= m_ok_next;
        m_data_reg   <= m_data_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        run_next      = run_reg;
        cnt_next      = cnt_reg;
        size_next     = size_reg;
        lo_next       = lo_reg;
        last_row_next = last_row_reg;
        last_off_next = last_off_reg;
        pend_ok_next  = pend_ok_reg;
        pend_blk_next = pend_blk_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_ok_next     = m_ok_reg;
        m_data_next   = m_data_reg;
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = row_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = row_reg + RA_W'(1);

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (row_reg == LAST_ROW)
                begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next = row_reg + RA_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                size_next     = in_size;
                run_next      = '0;
                pend_ok_next  = 1'b0;
                pend_blk_next = '0;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0] == OP_ALLOC)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        row_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (s_axis_tuser[1])
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!start_ok)
                    begin
                        pend_ok_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = start_u[RA_W+OFF_W-1:OFF_W];
                        row_next   = start_u[RA_W+OFF_W-1:OFF_W];
                        lo_next    = start_u[OFF_W-1:0];
                        state_next = ST_FREE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (res.found)
                begin
                    cnt_next      = cnt_add_w[U_W-1:0];
                    pend_ok_next  = 1'b1;
                    pend_blk_next = blk_u;
                    if (size_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = blk_u[RA_W+OFF_W-1:OFF_W];
                        row_next      = blk_u[RA_W+OFF_W-1:OFF_W];
                        lo_next       = blk_u[OFF_W-1:0];
                        last_row_next = last_u[RA_W+OFF_W-1:OFF_W];
                        last_off_next = last_u[OFF_W-1:0];
                        state_next    = ST_MARK;
                    end
                end
                else if (row_reg == LAST_ROW)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    row_next = row_reg + RA_W'(1);
                    run_next = run_out;
                end
            end
            ST_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = set_data;
                if (row_reg == last_row_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    row_next = row_reg + RA_W'(1);
                    lo_next  = '0;
                end
            end
            ST_FREE:
            begin
                wr_en    = 1'b1;
                wr_data  = clr_data;
                cnt_next = cnt_reg - U_W'(res.n_clr);
                if (res.stop || row_reg == LAST_ROW)
                begin
                    pend_ok_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    row_next = row_reg + RA_W'(1);
                    lo_next  = '0;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_ok_next    = pend_ok_reg;
                    m_data_next  = {3'b000, cnt_out_w[USED_W-1:0], blk_out_w[BLOCK_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_ok_reg;

endmodule

FILE: rtl/bffa_checker.sv
module bffa_checker import bffa_pkg::*; #(
    parameter int POOL_UNITS = 1024
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser
);

    // one transaction in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in flight");

    // failed result carries no block start
    a_fail_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[BLOCK_W-1:0] == '0)
        else $error("failed result with nonzero block_start");

    // used count never exceeds the pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (POOL_UNITS > 2047)
            || ({21'b0, m_axis_tdata[BLOCK_W+USED_W-1:BLOCK_W]} <= POOL_UNITS))
        else $error("used_units above pool size");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind bitmap_first_fit_allocator bffa_checker #(
    .POOL_UNITS (POOL_UNITS)
) u_bffa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
